[src/cpr_pkg.sv]
// Shared types and constants for the clock page replacement unit.
package cpr_pkg;

  localparam int SLOTS     = 16;
  localparam int PROCESSES = 4;
  localparam int SLOT_W    = 4;
  localparam int PROC_W    = 2;
  localparam int COUNT_W   = 5;
  localparam int PAGE_W    = 12;
  localparam int FRAME_W   = 10;
  localparam int CMD_W     = 3;
  localparam int ADDR_W    = PROC_W + SLOT_W;
  localparam int ENTRIES   = PROCESSES * SLOTS;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 3'd0,
    CMD_READ    = 3'd1,
    CMD_WRITE   = 3'd2,
    CMD_REPLACE = 3'd3,
    CMD_SUSPEND = 3'd4
  } command_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_EMPTY        = 2'd2,
    ST_NOT_RESIDENT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ACCESS,
    S_SCAN,
    S_LIST,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic               use_bit;
    logic               dirty;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } ram_wr_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  victim_slot;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FRAME_W-1:0] evicted_frame;
    logic               write_back;
    logic               last;
  } result_t;

endpackage

[src/cpr_if.sv]
// Handshake interfaces for the request, response and configuration channels.
interface cpr_req_if import cpr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [PROC_W-1:0]  process;
  logic [SLOT_W-1:0]  slot;
  logic [FRAME_W-1:0] frame;
  logic [PAGE_W-1:0]  page;

  modport source (output valid, command, process, slot, frame, page, input ready);
  modport sink (input valid, command, process, slot, frame, page, output ready);
endinterface

interface cpr_rsp_if import cpr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [SLOT_W-1:0]  victim_slot;
  logic [PAGE_W-1:0]  evicted_page;
  logic [FRAME_W-1:0] evicted_frame;
  logic               write_back;
  logic               last;

  modport source (output valid, status, victim_slot, evicted_page, evicted_frame,
                  write_back, last, input ready);
  modport sink (input valid, status, victim_slot, evicted_page, evicted_frame,
                write_back, last, output ready);
endinterface

interface cpr_cfg_if ();
  logic valid;
  logic ready;
  logic enhanced_mode;

  modport source (output valid, enhanced_mode, input ready);
  modport sink (input valid, enhanced_mode, output ready);
endinterface

[src/cpr_entry_ram.sv]
// Resident entry memory with one write port and one registered read port.
module cpr_entry_ram import cpr_pkg::*; (
  input  logic              clk,
  input  ram_wr_t           wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [ENTRIES];

  // A read of the entry being written returns the new data.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (wr.en && (wr.addr == rd_addr)) begin
      rd_data <= wr.data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/clock_page_replacement_unit.sv]
// Top level of the clock page replacement unit: command sequencer around the entry memory.
// One command is in work at a time. A replace moves the hand over one entry per visit, at most
// 3*count+1 visits in enhanced mode, so 49 for a full ring; a suspend lists every resident
// entry in slot order. A new request is taken only after the last result is registered, and a
// stalled response holds the unit. Synchronous reset clears state, response valid, mode,
// counts and hands; the entry memory and payload registers are not reset.
module clock_page_replacement_unit import cpr_pkg::*; (
  input logic       clk,
  input logic       rst,
  cpr_cfg_if.sink   cfg,
  cpr_req_if.sink   req,
  cpr_rsp_if.source rsp
);

  // Configuration register. The user must write it only while the unit is idle; the unit
  // does not enforce this itself, and the port is always open.
  logic enhanced_mode;

  // Per-process ring bookkeeping.
  logic [COUNT_W-1:0] resident_count [PROCESSES];
  logic [SLOT_W-1:0]  clock_hand [PROCESSES];

  // Sequencer state and the latched request.
  state_t             state, state_next;
  logic [CMD_W-1:0]   cmd_q;
  logic [PROC_W-1:0]  proc_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [FRAME_W-1:0] frame_q;
  logic [PAGE_W-1:0]  page_q;
  // The hand while scanning, the list position while suspending.
  logic [SLOT_W-1:0]  hand_q;
  logic               pass2_q;
  logic               more_q;
  result_t            res_q;

  // Output register.
  logic    rsp_valid;
  result_t rsp_data;

  // Memory ports.
  ram_wr_t           wr;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_data;

  // Shared decode of the current command.
  logic [COUNT_W-1:0] cur_count;
  logic [SLOT_W-1:0]  start_hand;
  logic [SLOT_W-1:0]  hand_inc;
  logic [SLOT_W-1:0]  scan_next;
  logic               at_end;
  logic               hit;
  logic               list_last;
  logic               out_free;
  logic               req_fire;
  result_t            dec_res;
  logic [SLOT_W-1:0]  dec_hand;

  cpr_entry_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req_fire  = req.valid && req.ready;
  assign cur_count = resident_count[proc_q];
  // A hand at or beyond the count restarts from the first slot.
  assign start_hand = ({1'b0, clock_hand[proc_q]} >= cur_count) ? '0 : clock_hand[proc_q];
  assign hand_inc   = hand_q + 1'b1;
  assign at_end     = ({1'b0, hand_q} + COUNT_W'(1)) >= cur_count;
  assign scan_next  = at_end ? '0 : hand_inc;
  assign list_last  = ({1'b0, hand_q} + COUNT_W'(1)) == cur_count;
  assign out_free   = !rsp_valid || rsp.ready;

  // Plain clock takes the first entry with a clear use bit. The enhanced scan
  // looks for unused clean entries on the first pass and unused dirty ones on
  // the second, clearing use bits only during the second pass.
  always_comb begin
    if (!enhanced_mode) begin
      hit = !rd_data.use_bit;
    end else begin
      hit = !rd_data.use_bit && (pass2_q ? rd_data.dirty : !rd_data.dirty);
    end
  end

  // Result and starting hand prepared while a command is decoded. Error
  // results carry only their status and the last flag.
  always_comb begin
    dec_res      = '0;
    dec_res.last = 1'b1;
    dec_hand     = '0;
    case (command_t'(cmd_q))
      CMD_LOAD: begin
        if (cur_count < COUNT_W'(SLOTS)) begin
          dec_res.victim_slot = cur_count[SLOT_W-1:0];
        end else begin
          dec_res.status = ST_FULL;
        end
      end
      CMD_READ, CMD_WRITE: begin
        if (cur_count == '0) begin
          dec_res.status = ST_EMPTY;
        end else if ({1'b0, slot_q} >= cur_count) begin
          dec_res.status = ST_NOT_RESIDENT;
        end
      end
      CMD_REPLACE: begin
        dec_hand = start_hand;
        if (cur_count == '0) begin
          dec_res.status = ST_EMPTY;
        end
      end
      CMD_SUSPEND: begin
        if (cur_count == '0) begin
          dec_res.status = ST_EMPTY;
        end
      end
      default: begin
        dec_res.status = ST_OK;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (command_t'(cmd_q))
          CMD_LOAD: state_next = S_EMIT;
          CMD_READ, CMD_WRITE: begin
            if (cur_count == '0 || {1'b0, slot_q} >= cur_count) begin
              state_next = S_EMIT;
            end else begin
              state_next = S_ACCESS;
            end
          end
          CMD_REPLACE: state_next = (cur_count == '0) ? S_EMIT : S_SCAN;
          CMD_SUSPEND: state_next = (cur_count == '0) ? S_EMIT : S_LIST;
          default:     state_next = S_IDLE;
        endcase
      end
      S_ACCESS: state_next = S_EMIT;
      S_SCAN: begin
        if (hit) begin
          state_next = S_EMIT;
        end
      end
      S_LIST: state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_next = more_q ? S_LIST : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake and memory port control.
  always_comb begin
    req.ready = (state == S_IDLE);
    cfg.ready = 1'b1;
    rd_addr   = {proc_q, hand_q};
    wr        = '0;
    wr.addr   = {proc_q, hand_q};
    case (state)
      S_DECODE: begin
        case (command_t'(cmd_q))
          CMD_LOAD: begin
            wr.addr = {proc_q, cur_count[SLOT_W-1:0]};
            wr.data = '{page: page_q, frame: frame_q, use_bit: 1'b0, dirty: 1'b0};
            wr.en   = (cur_count < COUNT_W'(SLOTS));
          end
          CMD_READ, CMD_WRITE: rd_addr = {proc_q, slot_q};
          CMD_REPLACE:         rd_addr = {proc_q, start_hand};
          CMD_SUSPEND:         rd_addr = {proc_q, {SLOT_W{1'b0}}};
          default:             rd_addr = {proc_q, hand_q};
        endcase
      end
      S_ACCESS: begin
        // Read-modify-write of the accessed entry's status bits.
        wr.en           = 1'b1;
        wr.addr         = {proc_q, slot_q};
        wr.data         = rd_data;
        wr.data.use_bit = 1'b1;
        wr.data.dirty   = rd_data.dirty || (command_t'(cmd_q) == CMD_WRITE);
      end
      S_SCAN: begin
        if (hit) begin
          // The new page takes over the victim's frame with both bits clear.
          wr.en   = 1'b1;
          wr.data = '{page: page_q, frame: rd_data.frame, use_bit: 1'b0, dirty: 1'b0};
        end else begin
          wr.en           = !enhanced_mode || pass2_q;
          wr.data         = rd_data;
          wr.data.use_bit = 1'b0;
          rd_addr         = {proc_q, scan_next};
        end
      end
      S_EMIT:  rd_addr = {proc_q, hand_inc};
      default: rd_addr = {proc_q, hand_q};
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      enhanced_mode <= 1'b0;
      rsp_valid     <= 1'b0;
      more_q        <= 1'b0;
      for (int i = 0; i < PROCESSES; i++) begin
        resident_count[i] <= '0;
        clock_hand[i]     <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        enhanced_mode <= cfg.enhanced_mode;
      end
      if (state == S_EMIT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_DECODE: begin
          more_q <= 1'b0;
          if (command_t'(cmd_q) == CMD_LOAD && cur_count < COUNT_W'(SLOTS)) begin
            resident_count[proc_q] <= cur_count + 1'b1;
          end
          if (command_t'(cmd_q) == CMD_SUSPEND && cur_count == '0) begin
            clock_hand[proc_q] <= '0;
          end
        end
        S_SCAN: begin
          if (hit) begin
            clock_hand[proc_q] <= scan_next;
          end
        end
        S_LIST: begin
          more_q <= !list_last;
          if (list_last) begin
            resident_count[proc_q] <= '0;
            clock_hand[proc_q]     <= '0;
          end
        end
        default: begin
          more_q <= more_q;
        end
      endcase
    end
  end

  // Request, scan and result payload registers.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd_q   <= req.command;
      proc_q  <= req.process;
      slot_q  <= req.slot;
      frame_q <= req.frame;
      page_q  <= req.page;
    end
    case (state)
      S_DECODE: begin
        res_q   <= dec_res;
        pass2_q <= 1'b0;
        hand_q  <= dec_hand;
      end
      S_ACCESS: begin
        res_q.victim_slot <= slot_q;
      end
      S_SCAN: begin
        if (hit) begin
          res_q <= '{status: ST_OK, victim_slot: hand_q, evicted_page: rd_data.page,
                     evicted_frame: rd_data.frame, write_back: rd_data.dirty, last: 1'b1};
        end else begin
          hand_q <= scan_next;
          if (enhanced_mode && at_end) begin
            pass2_q <= !pass2_q;
          end
        end
      end
      S_LIST: begin
        res_q <= '{status: ST_OK, victim_slot: hand_q, evicted_page: rd_data.page,
                   evicted_frame: rd_data.frame, write_back: rd_data.dirty,
                   last: list_last};
      end
      S_EMIT: begin
        if (out_free) begin
          rsp_data <= res_q;
          if (more_q) begin
            hand_q <= hand_inc;
          end
        end
      end
      default: begin
        hand_q <= hand_q;
      end
    endcase
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_data.status;
  assign rsp.victim_slot   = rsp_data.victim_slot;
  assign rsp.evicted_page  = rsp_data.evicted_page;
  assign rsp.evicted_frame = rsp_data.evicted_frame;
  assign rsp.write_back    = rsp_data.write_back;
  assign rsp.last          = rsp_data.last;

  // The scan and list pointers always stay inside the resident part of the ring.
  a_hand_in_ring: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_LIST) |-> ({1'b0, hand_q} < cur_count))
    else $error("ring pointer beyond resident count");

  // No resident set in work ever holds more entries than the ring has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (cur_count <= COUNT_W'(SLOTS)))
    else $error("resident count above ring size");

  // The memory is only written while a command is in work.
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_EMIT) |-> !wr.en)
    else $error("entry write outside command execution");

  // Listing the last entry of a suspend empties the set and rewinds its hand.
  a_suspend_empties: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST && list_last) |=> (cur_count == '0 && clock_hand[proc_q] == '0))
    else $error("suspend left entries resident");

endmodule

[verif/tb.sv]
// Self-checking testbench for the clock page replacement unit.
module tb;
  import cpr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Command codes above suspend are undefined; the unit must swallow them
  // without producing a response.
  localparam logic [CMD_W-1:0] CMD_UNDEFINED_LO = CMD_SUSPEND + 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNDEFINED_HI = '1;

  localparam bit MODE_PLAIN    = 1'b0;
  localparam bit MODE_ENHANCED = 1'b1;

  localparam int unsigned FRAME_MAX = (1 << FRAME_W) - 1;
  localparam int unsigned PAGE_MAX  = (1 << PAGE_W) - 1;

  // The slowest command is an enhanced replace on a full ring. After the
  // last response we let this many cycles pass so that an undefined command
  // still in the pipe cannot overlap a mode change.
  localparam int unsigned SETTLE_CYCLES = 80;
  // Upper bound on how long the responses of the last requests may trail.
  localparam int unsigned DRAIN_LIMIT   = 4000;
  // About 320 requests, each at most 16 responses under random back
  // pressure plus the scan time, stay well below this limit.
  localparam int unsigned CYCLE_LIMIT   = 500_000;
  localparam int unsigned IDLE_PERCENT  = 27;
  localparam int unsigned PRINT_LIMIT   = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cpr_cfg_if cfg_ch ();
  cpr_req_if req_ch ();
  cpr_rsp_if rsp_ch ();

  clock_page_replacement_unit i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow copy of the resident sets. It is updated at the clock edge at
  // which a request is taken, so the expected responses are queued long
  // before the unit can return them.
  // ---------------------------------------------------------------------
  logic [PAGE_W-1:0]  ring_page  [ENTRIES];
  logic [FRAME_W-1:0] ring_frame [ENTRIES];
  bit                 ring_use   [ENTRIES];
  bit                 ring_dirty [ENTRIES];
  int unsigned        resident   [PROCESSES];
  int unsigned        hand       [PROCESSES];
  bit                 enhanced;

  result_t expected_results[$];

  int unsigned failures;
  int unsigned cycle_count;
  int unsigned n_loads, n_accesses, n_replaces, n_suspends, n_ignored;
  int unsigned n_errors, n_full, n_write_backs, n_checked;

  // When set, neither the request side nor the response side ever pauses.
  bit no_stalls;

  task automatic report_failure(string msg);
    failures++;
    if (failures <= PRINT_LIMIT) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  function automatic result_t make_result(status_t st, logic [SLOT_W-1:0] sl,
                                          logic [PAGE_W-1:0] pg,
                                          logic [FRAME_W-1:0] fr,
                                          logic wb, logic lst);
    result_t r;
    r.status        = st;
    r.victim_slot   = sl;
    r.evicted_page  = pg;
    r.evicted_frame = fr;
    r.write_back    = wb;
    r.last          = lst;
    return r;
  endfunction

  // Runs the clock hand of one process until it rests on the victim.
  // Plain mode gives each used entry a second chance by clearing its use
  // bit. Enhanced mode alternates two sweeps over the ring: the first looks
  // for a clean, unused entry and touches nothing; the second looks for a
  // dirty, unused entry and clears use bits as it goes.
  function automatic int unsigned pick_victim(int unsigned p, int unsigned cnt);
    int unsigned base, h, sweep, idx, step;
    bit hit;
    base  = p * SLOTS;
    h     = (hand[p] >= cnt) ? 0 : hand[p];
    sweep = 1;
    for (step = 0; step < 4 * SLOTS + 4; step++) begin
      idx = base + h;
      if (!enhanced) begin
        if (!ring_use[idx]) break;
        ring_use[idx] = 1'b0;
        h = (h + 1 >= cnt) ? 0 : h + 1;
      end else begin
        hit = !ring_use[idx] && ((sweep == 1) ? !ring_dirty[idx] : ring_dirty[idx]);
        if (hit) break;
        if (sweep == 2) ring_use[idx] = 1'b0;
        if (h + 1 >= cnt) begin
          sweep = (sweep == 1) ? 2 : 1;
          h = 0;
        end else begin
          h++;
        end
      end
    end
    return h;
  endfunction

  // Applies one accepted request to the shadow sets and queues the
  // responses that it must produce.
  task automatic predict_request(logic [CMD_W-1:0] cmd, logic [PROC_W-1:0] pr,
                                 logic [SLOT_W-1:0] sl, logic [FRAME_W-1:0] fr,
                                 logic [PAGE_W-1:0] pg);
    int unsigned p, base, cnt, v, idx, k;
    p    = int'(pr);
    base = p * SLOTS;
    cnt  = resident[p];
    case (cmd)
      CMD_LOAD: begin
        n_loads++;
        if (cnt >= SLOTS) begin
          n_full++;
          n_errors++;
          expected_results.push_back(make_result(ST_FULL, '0, '0, '0, 1'b0, 1'b1));
        end else begin
          idx = base + cnt;
          ring_page[idx]  = pg;
          ring_frame[idx] = fr;
          ring_use[idx]   = 1'b0;
          ring_dirty[idx] = 1'b0;
          resident[p]     = cnt + 1;
          expected_results.push_back(make_result(ST_OK, SLOT_W'(cnt), '0, '0, 1'b0, 1'b1));
        end
      end
      CMD_READ, CMD_WRITE: begin
        n_accesses++;
        if (cnt == 0) begin
          n_errors++;
          expected_results.push_back(make_result(ST_EMPTY, '0, '0, '0, 1'b0, 1'b1));
        end else if (int'(sl) >= cnt) begin
          n_errors++;
          expected_results.push_back(
            make_result(ST_NOT_RESIDENT, '0, '0, '0, 1'b0, 1'b1));
        end else begin
          idx = base + int'(sl);
          ring_use[idx] = 1'b1;
          if (cmd == CMD_WRITE) ring_dirty[idx] = 1'b1;
          expected_results.push_back(make_result(ST_OK, sl, '0, '0, 1'b0, 1'b1));
        end
      end
      CMD_REPLACE: begin
        n_replaces++;
        if (cnt == 0) begin
          n_errors++;
          expected_results.push_back(make_result(ST_EMPTY, '0, '0, '0, 1'b0, 1'b1));
        end else begin
          v   = pick_victim(p, cnt);
          idx = base + v;
          if (ring_dirty[idx]) n_write_backs++;
          expected_results.push_back(make_result(ST_OK, SLOT_W'(v), ring_page[idx],
                                                 ring_frame[idx], ring_dirty[idx], 1'b1));
          // The new page inherits the victim's frame and starts clean.
          ring_page[idx]  = pg;
          ring_use[idx]   = 1'b0;
          ring_dirty[idx] = 1'b0;
          hand[p] = (v + 1 >= cnt) ? 0 : v + 1;
        end
      end
      CMD_SUSPEND: begin
        n_suspends++;
        if (cnt == 0) begin
          n_errors++;
          expected_results.push_back(make_result(ST_EMPTY, '0, '0, '0, 1'b0, 1'b1));
        end else begin
          for (k = 0; k < cnt; k++) begin
            idx = base + k;
            if (ring_dirty[idx]) n_write_backs++;
            expected_results.push_back(make_result(ST_OK, SLOT_W'(k), ring_page[idx],
                                                   ring_frame[idx], ring_dirty[idx],
                                                   k + 1 == cnt));
          end
        end
        // Suspending also parks the hand, even on an empty set.
        resident[p] = 0;
        hand[p]     = 0;
      end
      default: n_ignored++;
    endcase
  endtask

  // Presents one request and returns at the edge where it is taken. Valid is
  // left high so that back-to-back requests need no extra assignment; it is
  // only lowered when the sender decides to pause or the test drains.
  task automatic send_request(logic [CMD_W-1:0] cmd, int unsigned pr, int unsigned sl,
                              int unsigned fr, int unsigned pg);
    if (!no_stalls && $urandom_range(99) < IDLE_PERCENT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PERCENT) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.process <= PROC_W'(pr);
    req_ch.slot    <= SLOT_W'(sl);
    req_ch.frame   <= FRAME_W'(fr);
    req_ch.page    <= PAGE_W'(pg);
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    predict_request(cmd, PROC_W'(pr), SLOT_W'(sl), FRAME_W'(fr), PAGE_W'(pg));
  endtask

  // Stops issuing and waits until every queued response has been seen,
  // then lets the unit settle.
  task automatic wait_until_drained();
    int unsigned waited;
    waited = 0;
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      report_failure($sformatf("%0d expected responses never arrived",
                               expected_results.size()));
      expected_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only ever called with the unit idle.
  task automatic set_replacement_mode(bit mode);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.enhanced_mode <= mode;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    enhanced = mode;
  endtask

  // Plain clock: error statuses on empty sets, undefined commands, loads
  // at the field extremes, accesses inside and outside the resident range,
  // second-chance replacement that evicts a dirty page, and a suspend.
  task automatic test_plain_clock_directed();
    set_replacement_mode(MODE_PLAIN);
    send_request(CMD_SUSPEND, 0, 0, 0, 0);
    send_request(CMD_READ, 1, 0, 0, 0);
    send_request(CMD_WRITE, 1, 0, 0, 0);
    send_request(CMD_REPLACE, 2, 0, 0, PAGE_MAX);
    for (int c = CMD_UNDEFINED_LO; c <= CMD_UNDEFINED_HI; c++)
      send_request(CMD_W'(c), PROCESSES - 1, SLOTS - 1, FRAME_MAX, PAGE_MAX);
    send_request(CMD_LOAD, 3, 0, FRAME_MAX, PAGE_MAX);
    send_request(CMD_LOAD, 3, SLOTS - 1, 0, 0);
    send_request(CMD_READ, 3, 0, 0, 0);
    send_request(CMD_WRITE, 3, 1, 0, 0);
    send_request(CMD_READ, 3, SLOTS - 1, 0, 0);
    send_request(CMD_WRITE, 3, 2, 0, 0);
    // Both entries are used, so the hand clears both and comes back to
    // slot 0; the next replace then takes the dirty slot 1.
    send_request(CMD_REPLACE, 3, 0, 0, 'hA5A);
    send_request(CMD_REPLACE, 3, 0, 0, 'h5A5);
    send_request(CMD_SUSPEND, 3, 0, 0, 0);
    wait_until_drained();
  endtask

  // Enhanced clock: every entry is used, so the first sweep finds nothing,
  // the second clears the use bits, and the third takes the clean page.
  task automatic test_enhanced_clock_directed();
    set_replacement_mode(MODE_ENHANCED);
    send_request(CMD_LOAD, 1, 0, 17, 'h111);
    send_request(CMD_LOAD, 1, 0, 18, 'h222);
    send_request(CMD_LOAD, 1, 0, 19, 'h333);
    send_request(CMD_WRITE, 1, 0, 0, 0);
    send_request(CMD_READ, 1, 1, 0, 0);
    send_request(CMD_WRITE, 1, 2, 0, 0);
    send_request(CMD_REPLACE, 1, 0, 0, 'h444);
    send_request(CMD_SUSPEND, 1, 0, 0, 0);
    wait_until_drained();
  endtask

  // Random traffic shaped like a real workload: sets fill up through loads,
  // pages get touched and replaced, and now and then a process is swapped
  // out. A small share is undefined commands and requests with random
  // operation and slot, which hit the error statuses.
  task automatic test_random_workload(bit mode, bit steady, int unsigned n_items);
    int unsigned p, cnt, roll, sl, sent;
    logic [CMD_W-1:0] cmd;
    set_replacement_mode(mode);
    no_stalls = steady;
    sent = 0;
    while (sent < n_items) begin
      p    = $urandom_range(PROCESSES - 1);
      cnt  = resident[p];
      roll = $urandom_range(99);
      sl   = $urandom_range(SLOTS - 1);
      if (roll < 4)
        cmd = CMD_W'($urandom_range(CMD_UNDEFINED_HI, CMD_UNDEFINED_LO));
      else if (roll < 10)
        cmd = CMD_W'($urandom_range(CMD_SUSPEND, CMD_LOAD));
      else if (cnt == 0 || (cnt < SLOTS && roll < 50) || (cnt == SLOTS && roll < 14))
        cmd = CMD_LOAD;
      else if (roll < 75) begin
        cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
        sl  = $urandom_range(cnt - 1);
      end else if (roll < 96)
        cmd = CMD_REPLACE;
      else
        cmd = CMD_SUSPEND;
      send_request(cmd, p, sl, $urandom_range(FRAME_MAX), $urandom_range(PAGE_MAX));
      if (cmd <= CMD_SUSPEND) sent++;
    end
    wait_until_drained();
    no_stalls = 1'b0;
  endtask

  // Response side: random back pressure unless a steady phase is running.
  always @(posedge clk) begin
    rsp_ch.ready <= no_stalls || ($urandom_range(99) >= IDLE_PERCENT);
  end

  task automatic check_field(string name, int unsigned index, logic [15:0] got,
                             logic [15:0] want);
    if (got !== want)
      report_failure($sformatf("response %0d: %s is %0h, expected %0h",
                               index, name, got, want));
  endtask

  // Every response taken is compared field by field with the oldest
  // expectation.
  always @(posedge clk) begin : check_responses
    result_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_failure($sformatf("unexpected response, status %0d slot %0d",
                                 rsp_ch.status, rsp_ch.victim_slot));
      end else begin
        want = expected_results.pop_front();
        check_field("status", n_checked, 16'(rsp_ch.status), 16'(want.status));
        check_field("victim_slot", n_checked, 16'(rsp_ch.victim_slot),
                    16'(want.victim_slot));
        check_field("evicted_page", n_checked, 16'(rsp_ch.evicted_page),
                    16'(want.evicted_page));
        check_field("evicted_frame", n_checked, 16'(rsp_ch.evicted_frame),
                    16'(want.evicted_frame));
        check_field("write_back", n_checked, 16'(rsp_ch.write_back),
                    16'(want.write_back));
        check_field("last", n_checked, 16'(rsp_ch.last), 16'(want.last));
        n_checked++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d responses outstanding",
               cycle_count, expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    req_ch.valid         <= 1'b0;
    req_ch.command       <= CMD_LOAD;
    req_ch.process       <= '0;
    req_ch.slot          <= '0;
    req_ch.frame         <= '0;
    req_ch.page          <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.enhanced_mode <= MODE_PLAIN;
    rst                  <= 1'b1;
    enhanced             = MODE_PLAIN;
    no_stalls            = 1'b0;
    for (int p = 0; p < PROCESSES; p++) begin
      resident[p] = 0;
      hand[p]     = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_plain_clock_directed();
    test_enhanced_clock_directed();
    test_random_workload(MODE_ENHANCED, 1'b0, 125);
    test_random_workload(MODE_PLAIN, 1'b1, 70);
    test_random_workload(MODE_ENHANCED, 1'b0, 90);

    $display("Covered %0d loads, %0d accesses, %0d replaces, %0d suspends and %0d %s",
             n_loads, n_accesses, n_replaces, n_suspends, n_ignored,
             "undefined commands in plain and enhanced mode");
    $display("Checked %0d responses: %0d error statuses (%0d full sets), %0d write-backs",
             n_checked, n_errors, n_full, n_write_backs);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
